// ----- rtl/mjpd_pkg.sv -----
// Package for the multi-joint PD torque controller.
// Holds shared widths, operation codes and configuration indexes; no dependencies.
package mjpd_pkg;

    // Joint table sizing.
    localparam int MAX_JOINTS  = 32;
    localparam int JOINT_W     = 5;
    localparam int JOINT_DEPTH = 1 << JOINT_W;

    // Field widths.
    localparam int ANGLE_W = 32;
    localparam int GAIN_W  = 32;
    localparam int LIMIT_W = 31;
    localparam int STEP_W  = 11;
    localparam int INVDT_W = 16;
    localparam int CFG_W   = 16;

    // Memory word widths.
    localparam int GAIN_WORD_W  = 2 * GAIN_W + LIMIT_W;
    localparam int STATE_WORD_W = 3 * ANGLE_W;

    // Reset values of the configuration registers.
    localparam logic [STEP_W-1:0]  STEPS_RESET = 11'd1;
    localparam logic [INVDT_W-1:0] INVDT_RESET = 16'd200;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_LOAD_GAINS = 2'd0,
        OP_INIT_JOINT = 2'd1,
        OP_SET_TARGET = 2'd2,
        OP_CONTROL    = 2'd3
    } t_op;

    // Configuration register indexes.
    localparam logic CFG_STEPS_PER_REF = 1'b0;
    localparam logic CFG_INV_DT        = 1'b1;

endpackage

// ----- rtl/mjpd_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module mjpd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- rtl/multi_joint_pd_torque_controller.sv -----
// Multi-joint PD torque controller with reference interpolation.
// Operations 0 and 1 complete at acceptance; operation 2 also rewrites the state table;
// a control step runs a restoring divider, skipped with a zero step count, then the
// error, multiply, accumulate and clamp states. One transaction is processed at a
// time; the next is accepted once the result is registered, later while a result waits.
// Reset is synchronous, active low; it restores the configuration defaults and clears
// the step counter; the joint tables stay undefined until written.
module multi_joint_pd_torque_controller
    import mjpd_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration write channel.
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [mjpd_pkg::CFG_W-1:0]  i_cfg_data,
    // Input channel.
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_operation,
    input  logic [mjpd_pkg::JOINT_W-1:0] i_joint_index,
    input  logic signed [mjpd_pkg::ANGLE_W-1:0] i_angle_value,
    input  logic [mjpd_pkg::GAIN_W-1:0] i_p_gain,
    input  logic [mjpd_pkg::GAIN_W-1:0] i_d_gain,
    input  logic [mjpd_pkg::LIMIT_W-1:0] i_torque_limit,
    input  logic                        i_end_of_tick,
    // Output channel.
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [mjpd_pkg::JOINT_W-1:0] o_out_joint,
    output logic signed [mjpd_pkg::ANGLE_W-1:0] o_torque,
    output logic                        o_tick_done
);

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_DIV, S_QREF, S_ERR, S_MUL1, S_MUL2, S_MUL3, S_MUL4,
        S_ACC, S_CLAMP, S_FIN
    } t_state;

    localparam int DIV_STEPS = ANGLE_W + 1;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int ACC_W     = 84;
    localparam int PROD_W    = 66;

    t_state r_state;
    logic [STEP_W-1:0]  r_steps_per_ref;
    logic [INVDT_W-1:0] r_inv_dt;
    logic [STEP_W-1:0]  r_step;
    logic               r_out_valid;

    // Latched item and operands.
    t_op                         r_op;
    logic [JOINT_W-1:0]          r_joint;
    logic signed [ANGLE_W-1:0]   r_q;
    logic                        r_eot;
    logic signed [ANGLE_W-1:0]   r_pa;
    logic signed [ANGLE_W-1:0]   r_ref_old;
    logic signed [ANGLE_W-1:0]   r_tgt;
    logic [GAIN_W-1:0]           r_pg;
    logic [GAIN_W-1:0]           r_dg;
    logic [LIMIT_W-1:0]          r_lim;

    // Datapath registers.
    logic [DIV_STEPS-1:0]        r_num;
    logic [STEP_W-1:0]           r_rem;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_neg;
    logic signed [ANGLE_W-1:0]   r_qref;
    logic signed [ANGLE_W:0]     r_e;
    logic signed [ANGLE_W+1:0]   r_dd;
    logic signed [50:0]          r_de;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [ACC_W-1:0]     r_acc;
    logic signed [ANGLE_W-1:0]   r_tq;

    // Memory ports.
    logic                        gain_we;
    logic [GAIN_WORD_W-1:0]      gain_rdata;
    logic                        state_we;
    logic [STATE_WORD_W-1:0]     state_wdata;
    logic [STATE_WORD_W-1:0]     state_rdata;

    logic in_acc;
    logic in_range;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign in_acc      = i_valid && o_ready;
    assign in_range    = (int'(i_joint_index) < MAX_JOINTS);

    // Memory write control: loads and inits at acceptance, read-modify-write otherwise.
    always_comb begin
        gain_we     = in_acc && in_range && (t_op'(i_operation) == OP_LOAD_GAINS);
        state_we    = 1'b0;
        state_wdata = {i_angle_value, i_angle_value, i_angle_value};
        if (in_acc && in_range && (t_op'(i_operation) == OP_INIT_JOINT)) begin
            state_we = 1'b1;
        end else if (r_state == S_READ && r_op == OP_SET_TARGET) begin
            state_we    = 1'b1;
            state_wdata = {state_rdata[STATE_WORD_W-1:ANGLE_W], r_q};
        end else if (r_state == S_CLAMP) begin
            state_we    = 1'b1;
            state_wdata = {r_q, r_qref, r_tgt};
        end
    end

    mjpd_ram #(.WIDTH(GAIN_WORD_W), .DEPTH(JOINT_DEPTH)) u_gain_ram (
        .i_clk   (i_clk),
        .i_we    (gain_we),
        .i_waddr (i_joint_index),
        .i_wdata ({i_p_gain, i_d_gain, i_torque_limit}),
        .i_raddr (i_joint_index),
        .o_rdata (gain_rdata)
    );

    mjpd_ram #(.WIDTH(STATE_WORD_W), .DEPTH(JOINT_DEPTH)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (state_we),
        .i_waddr ((r_state == S_IDLE) ? i_joint_index : r_joint),
        .i_wdata (state_wdata),
        .i_raddr (i_joint_index),
        .o_rdata (state_rdata)
    );

    // Restoring divider step, reference difference, interpolation, accumulate and clamp terms.
    logic [STEP_W:0]          div_trial;
    logic                     div_ge;
    logic signed [ANGLE_W:0]  ref_diff;
    logic [ANGLE_W:0]         ref_mag;
    logic signed [ANGLE_W+1:0] quo_signed;
    logic signed [ANGLE_W+1:0] qref_wide;
    logic signed [ACC_W-1:0]  hi_term;
    logic signed [59:0]       shifted;
    logic signed [59:0]       lim_pos;

    always_comb begin
        div_trial  = {r_rem, r_num[DIV_STEPS-1]};
        div_ge     = (div_trial >= {1'b0, r_step});
        ref_diff   = $signed({state_rdata[ANGLE_W-1], state_rdata[ANGLE_W-1:0]})
                     - $signed({state_rdata[2*ANGLE_W-1], state_rdata[2*ANGLE_W-1:ANGLE_W]});
        ref_mag    = ref_diff[ANGLE_W] ? (ANGLE_W + 1)'(0) - ref_diff : ref_diff;
        quo_signed = r_neg ? -$signed({1'b0, r_num}) : $signed({1'b0, r_num});
        qref_wide  = (ANGLE_W + 2)'(r_ref_old) + quo_signed;
        hi_term    = ACC_W'(r_prod[58:0] <<< 25);
        shifted    = r_acc[ACC_W-1:24];
        lim_pos    = $signed({29'd0, r_lim});
    end

    // Sequencer, configuration, step counter and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_steps_per_ref <= STEPS_RESET;
            r_inv_dt        <= INVDT_RESET;
            r_step          <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            // Configuration transactions.
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_STEPS_PER_REF: r_steps_per_ref <= i_cfg_data[STEP_W-1:0];
                    CFG_INV_DT:        r_inv_dt        <= i_cfg_data[INVDT_W-1:0];
                    default:           r_inv_dt        <= r_inv_dt;
                endcase
            end

            // The output transaction completes; the final state may refill it at once.
            if (r_out_valid && i_ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && in_range) begin
                        r_op    <= t_op'(i_operation);
                        r_joint <= i_joint_index;
                        r_q     <= i_angle_value;
                        r_eot   <= i_end_of_tick;
                        if (t_op'(i_operation) == OP_SET_TARGET ||
                            t_op'(i_operation) == OP_CONTROL) begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_pa      <= state_rdata[3*ANGLE_W-1:2*ANGLE_W];
                    r_ref_old <= state_rdata[2*ANGLE_W-1:ANGLE_W];
                    r_tgt     <= state_rdata[ANGLE_W-1:0];
                    r_pg      <= gain_rdata[GAIN_WORD_W-1:GAIN_W+LIMIT_W];
                    r_dg      <= gain_rdata[GAIN_W+LIMIT_W-1:LIMIT_W];
                    r_lim     <= gain_rdata[LIMIT_W-1:0];
                    r_neg     <= ref_diff[ANGLE_W];
                    r_rem     <= '0;
                    r_cnt     <= '0;
                    if (r_op == OP_SET_TARGET) begin
                        r_step  <= r_steps_per_ref;
                        r_state <= S_IDLE;
                    end else if (r_step == '0) begin
                        r_num   <= '0;
                        r_state <= S_QREF;
                    end else begin
                        r_num   <= ref_mag;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= div_ge ? STEP_W'(div_trial - {1'b0, r_step})
                                    : div_trial[STEP_W-1:0];
                    r_num <= {r_num[DIV_STEPS-2:0], div_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_QREF;
                    end
                end
                S_QREF: begin
                    r_qref  <= qref_wide[ANGLE_W-1:0];
                    r_state <= S_ERR;
                end
                S_ERR: begin
                    r_e  <= (ANGLE_W + 1)'(r_q) - (ANGLE_W + 1)'(r_qref);
                    r_dd <= ((ANGLE_W + 2)'(r_q) - (ANGLE_W + 2)'(r_pa))
                            - ((ANGLE_W + 2)'(r_qref) - (ANGLE_W + 2)'(r_ref_old));
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_de    <= 51'(r_dd * $signed({1'b0, r_inv_dt}));
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_prod  <= PROD_W'(r_e * $signed({1'b0, r_pg}));
                    r_state <= S_MUL3;
                end
                S_MUL3: begin
                    r_acc   <= -ACC_W'(r_prod);
                    r_prod  <= PROD_W'($signed({1'b0, r_de[24:0]}) * $signed({1'b0, r_dg}));
                    r_state <= S_MUL4;
                end
                S_MUL4: begin
                    r_acc   <= r_acc - ACC_W'(r_prod);
                    r_prod  <= PROD_W'($signed(r_de[50:25]) * $signed({1'b0, r_dg}));
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc   <= r_acc - hi_term;
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    if (shifted > lim_pos) begin
                        r_tq <= $signed({1'b0, r_lim});
                    end else if (shifted < -lim_pos) begin
                        r_tq <= -$signed({1'b0, r_lim});
                    end else begin
                        r_tq <= shifted[ANGLE_W-1:0];
                    end
                    if (r_eot && r_step != '0) begin
                        r_step <= r_step - 1'b1;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        o_out_joint <= r_joint;
                        o_torque    <= r_tq;
                        o_tick_done <= r_eot;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // The divider remainder always stays below the divisor.
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_step))
        else $error("divider remainder not below divisor");

    // A result appears only on leaving the final state.
    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result raised outside final state");

    // The iteration counter never runs past the divider length.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < CNT_W'(DIV_STEPS)))
        else $error("divider counter overrun");
`endif

endmodule

// ----- tb/multi_joint_pd_torque_controller_tb.sv -----
// Testbench for the multi-joint PD torque controller.
// Depends on mjpd_pkg and multi_joint_pd_torque_controller; self-checking, no files read.
`timescale 1ns / 1ps

module multi_joint_pd_torque_controller_tb;
    import mjpd_pkg::*;

    localparam int  RANDOM_ITEMS = 1250;
    localparam int  SETTLE       = 60;
    localparam int  CYCLE_LIMIT  = 600000;

    typedef struct {
        logic [JOINT_W-1:0]        joint;
        logic signed [ANGLE_W-1:0] torque;
        logic                      tick_done;
    } t_torque;

    // Scoreboard: shadow of the joint tables and registers, plus expected torques.
    class t_torque_scoreboard;
        logic [STEP_W-1:0]         steps_per_ref = STEPS_RESET;
        logic [INVDT_W-1:0]        inv_dt = INVDT_RESET;
        logic [STEP_W-1:0]         step_count = '0;
        logic signed [ANGLE_W-1:0] prev_angle [MAX_JOINTS];
        logic signed [ANGLE_W-1:0] prev_ref [MAX_JOINTS];
        logic signed [ANGLE_W-1:0] target [MAX_JOINTS];
        logic [GAIN_W-1:0]         p_tab [MAX_JOINTS];
        logic [GAIN_W-1:0]         d_tab [MAX_JOINTS];
        logic [LIMIT_W-1:0]        lim_tab [MAX_JOINTS];
        t_torque                   expected_torques [$];
        int                        errors = 0;
        int                        results_seen = 0;

        function void write_register(logic index, logic [CFG_W-1:0] data);
            if (index == CFG_STEPS_PER_REF) begin
                steps_per_ref = data[STEP_W-1:0];
            end else begin
                inv_dt = data[INVDT_W-1:0];
            end
        endfunction

        // Notes an accepted input transaction and predicts its torque, if any.
        function void note_input(t_op op, logic [JOINT_W-1:0] j,
                                 logic signed [ANGLE_W-1:0] ang, logic [GAIN_W-1:0] p,
                                 logic [GAIN_W-1:0] d, logic [LIMIT_W-1:0] lim, logic eot);
            longint                q;
            longint                ref_old;
            longint                q_ref;
            longint                e;
            longint                de;
            logic signed [127:0]   p_term;
            logic signed [127:0]   d_term;
            logic signed [127:0]   shifted;
            logic signed [127:0]   lim_w;
            t_torque               r;
            case (op)
                OP_LOAD_GAINS: begin
                    p_tab[j] = p;
                    d_tab[j] = d;
                    lim_tab[j] = lim;
                end
                OP_INIT_JOINT: begin
                    prev_angle[j] = ang;
                    prev_ref[j] = ang;
                    target[j] = ang;
                end
                OP_SET_TARGET: begin
                    target[j] = ang;
                    step_count = steps_per_ref;
                end
                default: begin
                    q = ang;
                    ref_old = prev_ref[j];
                    // Interpolate the reference, truncating the step toward zero.
                    if (step_count != 0) begin
                        q_ref = ref_old + (longint'(target[j]) - ref_old) / longint'(step_count);
                    end else begin
                        q_ref = ref_old;
                    end
                    e = q - q_ref;
                    de = ((q - longint'(prev_angle[j])) - (q_ref - ref_old)) * longint'(inv_dt);
                    prev_angle[j] = ang;
                    prev_ref[j] = q_ref[31:0];
                    p_term = e;
                    p_term = p_term * $signed({96'd0, p_tab[j]});
                    d_term = de;
                    d_term = d_term * $signed({96'd0, d_tab[j]});
                    shifted = (-p_term - d_term) >>> 24;
                    lim_w = $signed({97'd0, lim_tab[j]});
                    r.joint = j;
                    r.tick_done = eot;
                    if (shifted > lim_w) begin
                        r.torque = lim_w[31:0];
                    end else if (shifted < -lim_w) begin
                        r.torque = -lim_w[31:0];
                    end else begin
                        r.torque = shifted[31:0];
                    end
                    expected_torques.push_back(r);
                    if (eot && step_count != 0) begin
                        step_count = step_count - 1'b1;
                    end
                end
            endcase
        endfunction

        // Compares one output transaction with the oldest expected torque.
        function void check_result(t_torque got);
            t_torque want;
            results_seen++;
            if (expected_torques.size() == 0) begin
                errors++;
                $error("unexpected result: joint %0d torque %0d", got.joint, got.torque);
                return;
            end
            want = expected_torques.pop_front();
            if (got.joint !== want.joint) begin
                errors++;
                $error("out_joint: expected %0d, got %0d", want.joint, got.joint);
            end
            if (got.torque !== want.torque) begin
                errors++;
                $error("torque: expected %0d, got %0d", want.torque, got.torque);
            end
            if (got.tick_done !== want.tick_done) begin
                errors++;
                $error("tick_done: expected %0d, got %0d", want.tick_done, got.tick_done);
            end
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic                        i_cfg_index = 1'b0;
    logic [CFG_W-1:0]            i_cfg_data = '0;
    logic                        i_valid = 1'b0;
    logic                        o_ready;
    logic [1:0]                  i_operation = '0;
    logic [JOINT_W-1:0]          i_joint_index = '0;
    logic signed [ANGLE_W-1:0]   i_angle_value = '0;
    logic [GAIN_W-1:0]           i_p_gain = '0;
    logic [GAIN_W-1:0]           i_d_gain = '0;
    logic [LIMIT_W-1:0]          i_torque_limit = '0;
    logic                        i_end_of_tick = 1'b0;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    logic [JOINT_W-1:0]          o_out_joint;
    logic signed [ANGLE_W-1:0]   o_torque;
    logic                        o_tick_done;

    t_torque_scoreboard sb = new();
    int  cycles = 0;
    int  items_sent = 0;
    int  hold_cycles = 0;
    bit  hold_request = 1'b0;
    int  burst_left = 0;
    bit  sender_idles = 1'b1;

    multi_joint_pd_torque_controller dut (.*);

    always #1 i_clk = ~i_clk;

    // Cycle limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** multi_joint_pd_torque_controller: FAILED **");
            $finish;
        end
    end

    // Receiver: the stall pattern rotates through four modes, with long hold-offs on request.
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_cycles = 400;
            hold_request = 1'b0;
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_ready <= 1'b0;
        end else begin
            case ((cycles / 128) % 4)
                0: i_ready <= 1'b1;
                1: i_ready <= ($urandom_range(0, 1) == 1);
                2: i_ready <= ($urandom_range(0, 7) == 0);
                default: i_ready <= (cycles % 5 != 0);
            endcase
        end
    end

    // Output monitor.
    always @(posedge i_clk) begin
        t_torque got;
        if (i_rst_n && o_valid && i_ready) begin
            got.joint = o_out_joint;
            got.torque = o_torque;
            got.tick_done = o_tick_done;
            sb.check_result(got);
        end
    end

    // Drives one input transaction and waits for its acceptance.
    task automatic send_item(t_op op, logic [JOINT_W-1:0] j, logic signed [ANGLE_W-1:0] ang,
                             logic [GAIN_W-1:0] p, logic [GAIN_W-1:0] d,
                             logic [LIMIT_W-1:0] lim, logic eot);
        int gap;
        if (sender_idles && burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 4);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_joint_index <= j;
        i_angle_value <= ang;
        i_p_gain <= p;
        i_d_gain <= d;
        i_torque_limit <= lim;
        i_end_of_tick <= eot;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_input(op, j, ang, p, d, lim, eot);
        items_sent++;
    endtask

    // Waits for every expected torque, then lets any result-free operation finish.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_torques.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_register(logic index, logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_register(index, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Angle mix: mostly near the current range, sometimes anywhere.
    function automatic logic signed [ANGLE_W-1:0] pick_angle();
        if ($urandom_range(0, 3) == 0) begin
            return $urandom;
        end
        return $signed($urandom_range(0, 1 << 26)) - (1 << 25);
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        if ($urandom_range(0, 3) == 0) begin
            return $urandom;
        end
        return $urandom_range(0, 1 << 24);
    endfunction

    function automatic logic [LIMIT_W-1:0] pick_limit();
        if ($urandom_range(0, 2) == 0) begin
            return LIMIT_W'($urandom);
        end
        return LIMIT_W'($urandom_range(0, 1 << 26));
    endfunction

    task automatic random_item();
        int   pick;
        t_op  op;
        pick = $urandom_range(0, 99);
        op = pick < 10 ? OP_LOAD_GAINS : pick < 18 ? OP_INIT_JOINT :
             pick < 32 ? OP_SET_TARGET : OP_CONTROL;
        send_item(op, JOINT_W'($urandom_range(0, MAX_JOINTS - 1)), pick_angle(), pick_gain(),
                  pick_gain(), pick_limit(), $urandom_range(0, 3) == 0);
    endtask

    // Register settings per phase: reset values first, then extremes and zeros.
    int phase_steps [5] = '{1024, 0, 2047, 3, 1};
    int phase_invdt [5] = '{65535, 0, 1, 1000, 200};

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every joint gets gains and an initial angle so that no table read is undefined.
        sender_idles = 1'b0;
        for (int j = 0; j < MAX_JOINTS; j++) begin
            send_item(OP_LOAD_GAINS, JOINT_W'(j), '0, pick_gain(), pick_gain(), pick_limit(),
                      1'b0);
            send_item(OP_INIT_JOINT, JOINT_W'(j), pick_angle(), '0, '0, '0, 1'b1);
        end

        // Directed: gain and limit extremes, angle extremes, counter saturation.
        send_item(OP_LOAD_GAINS, 0, '0, '1, '1, '1, 1'b0);
        send_item(OP_LOAD_GAINS, 1, '0, '0, '0, '0, 1'b0);
        send_item(OP_LOAD_GAINS, 2, '0, 32'h0001_0000, '0, '1, 1'b0);
        send_item(OP_CONTROL, 0, 32'sh7FFF_FFFF, '0, '0, '0, 1'b0);
        send_item(OP_CONTROL, 0, 32'sh8000_0000, '0, '0, '0, 1'b1);
        send_item(OP_CONTROL, 1, 32'sh7FFF_FFFF, '0, '0, '0, 1'b1);
        send_item(OP_CONTROL, 2, 32'sh0100_0000, '0, '0, '0, 1'b1);
        send_item(OP_CONTROL, 2, '0, '0, '0, '0, 1'b1);
        send_item(OP_SET_TARGET, 0, 32'sh8000_0000, '0, '0, '0, 1'b1);
        send_item(OP_CONTROL, 0, '0, '0, '0, '0, 1'b1);
        send_item(OP_SET_TARGET, 2, 32'sh7FFF_FFFF, '0, '0, '0, 1'b0);
        send_item(OP_CONTROL, 2, -32'sd1, '0, '0, '0, 1'b1);
        send_item(OP_CONTROL, 2, -32'sd1, '0, '0, '0, 1'b1);
        send_item(OP_INIT_JOINT, 3, 32'sh8000_0000, '0, '0, '0, 1'b0);
        send_item(OP_CONTROL, 3, 32'sh7FFF_FFFF, '0, '0, '0, 1'b0);
        send_item(OP_LOAD_GAINS, 0, '0, pick_gain(), pick_gain(), pick_limit(), 1'b1);

        // Receiver holds off while the sender keeps offering control steps.
        hold_request = 1'b1;
        for (int k = 0; k < 8; k++) begin
            send_item(OP_CONTROL, JOINT_W'($urandom_range(0, MAX_JOINTS - 1)), pick_angle(),
                      '0, '0, '0, k == 7);
        end
        drain();

        // Random phases, one register setting each.
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                write_register(CFG_STEPS_PER_REF,
                               {5'($urandom), 11'(phase_steps[ph - 1])});
                write_register(CFG_INV_DT, 16'(phase_invdt[ph - 1]));
            end
            sender_idles = (ph != 2);
            for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
                random_item();
            end
            drain();
        end

        $display("Sent %0d transactions over six register settings; %0d torques checked.",
                 items_sent, sb.results_seen);
        if (sb.expected_torques.size() != 0) begin
            sb.errors++;
            $error("%0d expected torques never arrived", sb.expected_torques.size());
        end
        if (sb.errors == 0) begin
            $display("** multi_joint_pd_torque_controller: PASSED **");
        end else begin
            $display("** multi_joint_pd_torque_controller: FAILED **");
        end
        $finish;
    end

endmodule
